FILE: rtl/core/sob_pkg.sv
// Shared types and constants for the Sobel 3x3 gradient filter.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package sob_pkg;

    localparam int unsigned SOB_MAX_WIDTH = 2048;
    localparam int unsigned PIX_W         = 8;
    localparam int unsigned COL_W         = 12;
    localparam int unsigned ROW_W         = 16;
    localparam int unsigned CCOL_W        = 11;
    localparam int unsigned GRAD_W        = 8;

    localparam logic [COL_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd480;

    // Register map: index = paddr[2]
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } sob_reg_t;

    // Position info of one pixel, resolved when the word is accepted
    typedef struct packed {
        logic              interior;
        logic              frame_last;
        logic [CCOL_W-1:0] center_col;
        logic [ROW_W-1:0]  center_row;
    } sob_pos_t;

endpackage

FILE: rtl/core/sob_pos.sv
// Column/row counters of the raster scan and border classification.
// Depends on sob_pkg.
`timescale 1ns / 1ps

module sob_pos import sob_pkg::*; #(
    parameter int unsigned MAX_WIDTH = SOB_MAX_WIDTH,
    localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [COL_W-1:0] image_width,
    input  logic [ROW_W-1:0] image_height,
    output logic [AW-1:0]    store_idx,
    output sob_pos_t         pos
);

    localparam int unsigned MAXW_CLIP = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
    localparam logic [COL_W-1:0] MAXW_C = MAXW_CLIP[COL_W-1:0];

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    logic             line_end;
    logic             frame_end;
    logic [COL_W-1:0] col_m1;

    always_comb begin
        eff_w = (image_width > MAXW_C) ? MAXW_C : image_width;
        if (eff_w == '0) begin
            eff_w = COL_W'(1);
        end
        eff_h = (image_height == '0) ? ROW_W'(1) : image_height;
    end

    assign line_end  = (col_reg >= eff_w - COL_W'(1));
    assign frame_end = line_end && (row_reg >= eff_h - ROW_W'(1));
    assign col_m1    = col_reg - COL_W'(1);

    assign store_idx = (32'(col_reg) < MAX_WIDTH) ? AW'(col_reg) : AW'(MAX_WIDTH - 1);

    always_comb begin
        pos.interior   = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2)) &&
                         (col_reg < eff_w) && (row_reg < eff_h);
        pos.frame_last = frame_end;
        pos.center_col = col_m1[CCOL_W-1:0];
        pos.center_row = row_reg - ROW_W'(1);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (line_end) begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: rtl/core/sob_line_buf.sv
// Two line stores (two lines up, one line up) with registered read data
// and write-to-read forwarding. Depends on sob_pkg.
`timescale 1ns / 1ps

module sob_line_buf import sob_pkg::*; #(
    parameter int unsigned MAX_WIDTH = SOB_MAX_WIDTH,
    localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_upper,
    input  logic [PIX_W-1:0] wr_middle,
    output logic [PIX_W-1:0] upper_q,
    output logic [PIX_W-1:0] middle_q
);

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] upper_reg;
    logic [PIX_W-1:0] middle_reg;
    logic             fwd;

    assign fwd = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
    end

    // Hold the read data until the next word is accepted
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            upper_reg  <= fwd ? wr_upper  : upper_mem[rd_addr];
            middle_reg <= fwd ? wr_middle : middle_mem[rd_addr];
        end
    end

    assign upper_q  = upper_reg;
    assign middle_q = middle_reg;

endmodule

FILE: rtl/core/sob_window.sv
// 3x3 window shift registers and the Sobel kernels with abs/saturate.
// Depends on sob_pkg.
`timescale 1ns / 1ps

module sob_window import sob_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift,
    input  logic [PIX_W-1:0]  top,
    input  logic [PIX_W-1:0]  mid,
    input  logic [PIX_W-1:0]  bot,
    output logic [GRAD_W-1:0] gx_abs,
    output logic [GRAD_W-1:0] gy_abs
);

    // entries 0..2: column c-2 (upper, middle, lower); 3..5: column c-1
    logic [PIX_W-1:0] win_reg  [6];
    logic [PIX_W-1:0] win_next [6];
    logic [9:0]       gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [10:0] gx, gy;

    function automatic logic [GRAD_W-1:0] abs_sat(input logic signed [10:0] v);
        logic [10:0] a;
        a = v[10] ? 11'(-v) : 11'(v);
        return (a > 11'd255) ? GRAD_W'(255) : a[GRAD_W-1:0];
    endfunction

    always_comb begin
        gx_pos = 10'(top) + {1'b0, mid, 1'b0} + 10'(bot);
        gx_neg = 10'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + 10'(win_reg[2]);
        gy_pos = 10'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + 10'(bot);
        gy_neg = 10'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + 10'(top);
        gx     = signed'({1'b0, gx_pos}) - signed'({1'b0, gx_neg});
        gy     = signed'({1'b0, gy_pos}) - signed'({1'b0, gy_neg});
        gx_abs = abs_sat(gx);
        gy_abs = abs_sat(gy);
    end

    always_comb begin
        win_next[0] = win_reg[3];
        win_next[1] = win_reg[4];
        win_next[2] = win_reg[5];
        win_next[3] = top;
        win_next[4] = mid;
        win_next[5] = bot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (shift) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

FILE: rtl/core/sobel_3x3_abs_gradients_top.sv
// Top level of the Sobel 3x3 gradient filter: APB registers, pipeline
// control, result register. Depends on sob_pkg, sob_pos, sob_line_buf, sob_window.
`timescale 1ns / 1ps

// Sobel 3x3 filter over 8-bit gray pixels in raster order. One pixel word is
// accepted per clock unless a result is blocked at the output. Pixels pass the
// registered line-store read into stage 1, then the kernel math into the
// output register. Border pixels give no result. Frame size is set over APB
// (image_width at 0x0, image_height at 0x4); change it only while the block
// is idle (not enforced). Line stores hold MAX_WIDTH pixels per line.
module sobel_3x3_abs_gradients_top import sob_pkg::*; #(
    parameter int unsigned MAX_WIDTH = SOB_MAX_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    // gradient output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] grad_x_abs, [15:8] grad_y_abs,
                                   // [26:16] center_col, [42:27] center_row
    output logic        m_tlast    // frame_last
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);

    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic             cfg_wr;
    sob_reg_t         cfg_sel;

    logic             s_accept;
    logic [AW-1:0]    store_idx;
    sob_pos_t         pos;

    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [AW-1:0]    s1_idx_reg;
    sob_pos_t         s1_pos_reg;
    logic             s1_move;

    logic [PIX_W-1:0]  top, mid;
    logic [GRAD_W-1:0] gx_abs, gy_abs;

    logic        m_valid_reg, m_valid_next;
    logic [42:0] m_data_reg;
    logic        m_last_reg;
    logic        m_load;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_sel = sob_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[COL_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Stage 1 drains unless it carries a result that the output cannot take
    assign m_load   = s1_valid_reg && s1_pos_reg.interior;
    assign s1_move  = s1_valid_reg && (!s1_pos_reg.interior || !m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_accept = s_tvalid && s_tready;

    sob_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (s_accept),
        .image_width  (width_reg),
        .image_height (height_reg),
        .store_idx    (store_idx),
        .pos          (pos)
    );

    sob_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
        .aclk      (aclk),
        .rd_en     (s_accept),
        .rd_addr   (store_idx),
        .wr_en     (s1_move),
        .wr_addr   (s1_idx_reg),
        .wr_upper  (mid),
        .wr_middle (s1_pixel_reg),
        .upper_q   (top),
        .middle_q  (mid)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixel_reg <= s_tdata;
            s1_idx_reg   <= store_idx;
            s1_pos_reg   <= pos;
        end
    end

    sob_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (s1_move),
        .top     (top),
        .mid     (mid),
        .bot     (s1_pixel_reg),
        .gx_abs  (gx_abs),
        .gy_abs  (gy_abs)
    );

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_move && m_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move && m_load) begin
            m_data_reg <= {s1_pos_reg.center_row, s1_pos_reg.center_col, gy_abs, gx_abs};
            m_last_reg <= s1_pos_reg.frame_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg};
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // Stage 1 may only hold when a result is blocked at the output
    a_s1_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_move |-> m_valid_reg && !m_tready)
        else $error("stage 1 held without output backpressure");

    a_s1_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> s1_valid_reg)
        else $error("accepted word lost before stage 1");

    a_center: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[26:16] != 11'd0) && (m_tdata[42:27] != 16'd0))
        else $error("result emitted for a border pixel");
`endif

endmodule

FILE: tb/sv/sobel_3x3_abs_gradients_top_tb.sv
// Testbench for sobel_3x3_abs_gradients_top: streams gray frames, predicts each
// gradient word in-bench and checks every result field and the register readback.
// Depends on sob_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module sobel_3x3_abs_gradients_top_tb;
    import sob_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PRINT_LIMIT  = 50;

    typedef struct packed {
        logic [GRAD_W-1:0] gx_abs;
        logic [GRAD_W-1:0] gy_abs;
        logic [CCOL_W-1:0] col;
        logic [ROW_W-1:0]  row;
        logic              last;
    } grad_word_t;

    typedef enum {PAT_NOISE, PAT_EDGE, PAT_RAMP, PAT_BINARY} pixel_pattern_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] pixel
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // [7:0] grad_x_abs, [15:8] grad_y_abs,
                             // [26:16] center_col, [42:27] center_row
    logic        m_tlast;    // frame_last

    // predictor state
    bit [7:0]    upper_line  [SOB_MAX_WIDTH];
    bit [7:0]    middle_line [SOB_MAX_WIDTH];
    bit [7:0]    win [6];
    int unsigned pos_col = 0;
    int unsigned pos_row = 0;
    int unsigned cfg_width  = WIDTH_RESET;
    int unsigned cfg_height = HEIGHT_RESET;
    grad_word_t  grad_q [$];

    int unsigned mismatch_count = 0;
    int unsigned sent_pixels    = 0;
    bit          idle_on        = 1'b1;

    sobel_3x3_abs_gradients_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("sobel_3x3_abs_gradients_top: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int unsigned sat_abs(input int v);
        int unsigned a;
        a = (v < 0) ? -v : v;
        return (a > 255) ? 255 : a;
    endfunction

    // Advance the predictor by one pixel and queue the gradient word it causes, if any.
    function automatic void predict_gradients(input bit [7:0] px);
        int unsigned ew, eh, c, r, idx;
        int          gx, gy;
        bit [7:0]    top, mid;
        bit          line_end, frame_end;
        grad_word_t  g;
        ew = (cfg_width > SOB_MAX_WIDTH) ? SOB_MAX_WIDTH : cfg_width;
        if (ew == 0) ew = 1;
        eh = (cfg_height == 0) ? 1 : cfg_height;
        c = pos_col;
        r = pos_row;
        idx = (c < SOB_MAX_WIDTH) ? c : SOB_MAX_WIDTH - 1;
        top = upper_line[idx];
        mid = middle_line[idx];
        line_end  = (c + 1 >= ew);
        frame_end = line_end && (r + 1 >= eh);
        if (c >= 2 && r >= 2 && c < ew && r < eh) begin
            gx = (int'(top) + 2 * int'(mid) + int'(px))
               - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
            gy = (int'(win[2]) + 2 * int'(win[5]) + int'(px))
               - (int'(win[0]) + 2 * int'(win[3]) + int'(top));
            g.gx_abs = GRAD_W'(sat_abs(gx));
            g.gy_abs = GRAD_W'(sat_abs(gy));
            g.col    = CCOL_W'(c - 1);
            g.row    = ROW_W'(r - 1);
            g.last   = frame_end;
            grad_q.push_back(g);
        end
        upper_line[idx]  = mid;
        middle_line[idx] = px;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = px;
        if (line_end) begin
            pos_col = 0;
            pos_row = frame_end ? 0 : ((r + 1) & 32'hFFFF);
        end else begin
            pos_col = c + 1;
        end
    endfunction

    // ---------------- result side ----------------

    initial begin : ready_driver
        int unsigned stall_left;
        stall_left = 0;
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15);
                m_tready <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        grad_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (grad_q.size() == 0) begin
                report_mismatch("gradient word with none expected", m_tdata, 0);
            end else begin
                want = grad_q.pop_front();
                if (m_tdata[7:0] !== want.gx_abs)
                    report_mismatch("grad_x_abs", m_tdata[7:0], want.gx_abs);
                if (m_tdata[15:8] !== want.gy_abs)
                    report_mismatch("grad_y_abs", m_tdata[15:8], want.gy_abs);
                if (m_tdata[26:16] !== want.col)
                    report_mismatch("center_col", m_tdata[26:16], want.col);
                if (m_tdata[42:27] !== want.row)
                    report_mismatch("center_row", m_tdata[42:27], want.row);
                if (m_tdata[47:43] !== 5'd0)
                    report_mismatch("tdata padding", m_tdata[47:43], 0);
                if (m_tlast !== want.last)
                    report_mismatch("frame_last", m_tlast, want.last);
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic apb_access(input sob_reg_t rg, input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {rg, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_register(input sob_reg_t rg);
        logic [31:0] rd;
        apb_access(rg, 1'b0, '0, rd);
        if (rd !== ((rg == REG_IMAGE_WIDTH) ? cfg_width : cfg_height))
            report_mismatch(rg.name(), rd, (rg == REG_IMAGE_WIDTH) ? cfg_width : cfg_height);
    endtask

    task automatic write_register(input sob_reg_t rg, input int unsigned value);
        logic [31:0] rd;
        apb_access(rg, 1'b1, value, rd);
        if (rg == REG_IMAGE_WIDTH) cfg_width = value & 32'hFFF;
        else cfg_height = value & 32'hFFFF;
        check_register(rg);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
    endtask

    // Send one pixel word; valid stays high afterwards unless a gap follows.
    task automatic send_pixel(input bit [7:0] px);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        predict_gradients(px);
        sent_pixels++;
    endtask

    // Drop valid, let every expected word come out, then let the pipeline settle.
    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (grad_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic bit [7:0] next_pixel(input pixel_pattern_t pat);
        case (pat)
            PAT_NOISE: return 8'($urandom_range(0, 255));
            PAT_EDGE: begin
                if ((pos_col + pos_row) % 6 < 3) return 8'($urandom_range(220, 255));
                return 8'($urandom_range(0, 35));
            end
            PAT_RAMP: return 8'(pos_col * 17 + pos_row * 29);
            default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // Send pixels until the frame counters wrap back to the origin.
    task automatic send_frame(input pixel_pattern_t pat);
        do send_pixel(next_pixel(pat)); while (pos_col != 0 || pos_row != 0);
    endtask

    // ---------------- tests ----------------

    task automatic test_register_defaults;
        check_register(REG_IMAGE_WIDTH);
        check_register(REG_IMAGE_HEIGHT);
    endtask

    // Smallest frame with an interior pixel: one word, horizontal edge (negative vertical gradient).
    task automatic test_min_frame;
        bit [7:0] pix [9] = '{8'hFF, 8'hFF, 8'hFF, 8'h09, 8'h09, 8'h09, 8'h00, 8'h00, 8'h00};
        wait_drained;
        set_frame(3, 3);
        foreach (pix[i]) send_pixel(pix[i]);
    endtask

    // Zero sizes act as one: each pixel is a frame of its own.
    task automatic test_zero_size;
        wait_drained;
        set_frame(0, 0);
        send_pixel(8'hAA);
        send_pixel(8'h55);
        send_pixel(8'h00);
    endtask

    // Mixed signs, saturated and unsaturated sums in one 4x3 frame.
    task automatic test_gradient_signs;
        bit [7:0] pix [12] = '{8'd10, 8'd20, 8'd30, 8'd40,
                               8'd1,  8'd2,  8'd3,  8'd4,
                               8'd200, 8'd100, 8'd50, 8'd25};
        wait_drained;
        set_frame(4, 3);
        foreach (pix[i]) send_pixel(pix[i]);
    endtask

    task automatic test_midframe_resize;
        wait_drained;
        set_frame(8, 65535);
        repeat (3 * 8 + 3) send_pixel(8'($urandom_range(0, 255)));
        // current row now lies past the last line: wrap at this line's end
        wait_drained;
        write_register(REG_IMAGE_HEIGHT, 2);
        send_frame(PAT_NOISE);
        send_frame(PAT_EDGE);
        wait_drained;
        set_frame(10, 6);
        repeat (2 * 10 + 8) send_pixel(8'($urandom_range(0, 255)));
        // shrink the line below the current column
        wait_drained;
        write_register(REG_IMAGE_WIDTH, 5);
        send_frame(PAT_RAMP);
    endtask

    task automatic test_random_frames(input int unsigned pixel_budget);
        int unsigned start, w, h;
        start = sent_pixels;
        while (sent_pixels - start < pixel_budget) begin
            case ($urandom_range(0, 15))
                0, 1: begin
                    w = $urandom_range(0, 2);
                    h = $urandom_range(0, 9);
                end
                2: begin
                    w = $urandom_range(3, 12);
                    h = $urandom_range(0, 2);
                end
                3: begin
                    w = $urandom_range(40, 200);
                    h = 3;
                end
                default: begin
                    w = $urandom_range(3, 20);
                    h = $urandom_range(3, 10);
                end
            endcase
            wait_drained;
            set_frame(w, h);
            idle_on = ($urandom_range(0, 3) != 0);
            send_frame(pixel_pattern_t'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_full_rate;
        wait_drained;
        idle_on = 1'b0;
        set_frame(16, 8);
        send_frame(PAT_NOISE);
        send_frame(PAT_EDGE);
    endtask

    initial begin
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_defaults;
        test_min_frame;
        test_zero_size;
        test_gradient_signs;
        test_midframe_resize;
        test_random_frames(850);
        test_full_rate;
        wait_drained;

        if (mismatch_count == 0 && grad_q.size() == 0)
            $display("sobel_3x3_abs_gradients_top: match");
        else
            $display("sobel_3x3_abs_gradients_top: mismatch");
        $finish;
    end

endmodule
